[rtl/ibdc_pkg.sv]
// ----------------------------------------------------------------------------
// ibdc_pkg
// Shared widths, codes and the request record for the instruction byte
// dedup cache.
// ----------------------------------------------------------------------------
package ibdc_pkg;

  // Fixed field widths of the request and result channels
  localparam int LEN_W  = 5;
  localparam int ADDR_W = 32;
  localparam int WORD_W = 64;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF   = 1024;
  localparam int MAX_BYTES_DEF = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = APB_ADDR_W - 2;

  // Register word indexes
  localparam logic [REG_SEL_W-1:0] REG_MODE = 1'b0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // One request as it travels down the pipeline
  typedef struct packed {
    logic              is_std;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } req_t;

endpackage

[rtl/insn_bytes_dedup_cache.sv]
// ----------------------------------------------------------------------------
// insn_bytes_dedup_cache
// Direct-mapped table of instruction bytes and lengths that removes repeated
// instruction bytes from a trace (encode) or puts them back (decode).
// ----------------------------------------------------------------------------
// Pipeline: the accepting edge loads stage 1, stages 2 and 3 finish the
//   index, stage 4 reads the table, then the output register.
// Throughput: one request per cycle while out_stall is low; the single
//   read-modify-write of the table per request, with one-entry write forwarding, sets that figure.
// Reset: synchronous; after rst the table is swept to zero, one entry a
//   cycle, with in_stall held high meanwhile.
module insn_bytes_dedup_cache #(
  parameter int ENTRIES   = ibdc_pkg::ENTRIES_DEF,
  parameter int MAX_BYTES = ibdc_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ibdc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ibdc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ibdc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            is_std,
  input  logic [ibdc_pkg::ADDR_W-1:0]     addr,
  input  logic [ibdc_pkg::LEN_W-1:0]      instr_len,
  input  logic [ibdc_pkg::WORD_W-1:0]     bytes_low,
  input  logic [ibdc_pkg::WORD_W-1:0]     bytes_high,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ibdc_pkg::LEN_W-1:0]      out_length,
  output logic [ibdc_pkg::WORD_W-1:0]     out_bytes_low,
  output logic [ibdc_pkg::WORD_W-1:0]     out_bytes_high,
  output logic                            hit
);
  import ibdc_pkg::*;

  // Table geometry
  localparam int IW = $clog2(ENTRIES);       // entry index width
  localparam int XW = IW + 1;                // residue width, holds < 2*ENTRIES
  localparam int DW = 8 * MAX_BYTES;         // stored byte lanes
  localparam int EW = LEN_W + DW;            // one table word: {len, bytes}
  localparam int BW = 2 * WORD_W;            // request byte vector

  // Entry = addr mod ENTRIES. The quotient estimate addr*RECIP >> 32 is
  // exact or one short, so one conditional subtract fixes the residue.
  localparam logic [31:0]   RECIP   = 32'((64'd1 << 32) / ENTRIES);
  localparam logic [XW-1:0] N_X     = XW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IX = IW'(ENTRIES - 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  mode_t                mode;
  logic [REG_SEL_W-1:0] reg_sel;
  logic                 cfg_wr;

  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (cfg_wr && reg_sel == REG_MODE) begin
      mode <= mode_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MODE) begin
      prdata[0] = mode;
    end
  end

  // --------------------------------------------------------------------------
  // Clearing sweep after reset
  // --------------------------------------------------------------------------
  logic          clearing;
  logic [IW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_IX) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: each stage loads when it is empty or draining
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign s4_ready  = !s4_valid || out_ready;
  assign s3_ready  = !s3_valid || s4_ready;
  assign s2_ready  = !s2_valid || s3_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  // hold off requests during the sweep
  assign in_stall  = clearing || !s1_ready;

  // --------------------------------------------------------------------------
  // Stage 1: register the request and the quotient estimate
  // --------------------------------------------------------------------------
  req_t          s1_req;
  logic [XW-1:0] s1_xlo;
  logic [31:0]   s1_q;
  logic [63:0]   quo_prod;

  assign quo_prod = addr * RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid && !clearing;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_req.is_std <= is_std;
      s1_req.len    <= instr_len;
      s1_req.hi     <= bytes_high;
      s1_req.lo     <= bytes_low;
      s1_xlo        <= addr[XW-1:0];
      s1_q          <= quo_prod[63:32];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: low bits of quotient * ENTRIES
  // --------------------------------------------------------------------------
  req_t          s2_req;
  logic [XW-1:0] s2_xlo;
  logic [XW-1:0] s2_qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_req <= s1_req;
      s2_xlo <= s1_xlo;
      s2_qn  <= XW'(s1_q[XW-1:0] * N_X);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: residue with one correction gives the entry index
  // --------------------------------------------------------------------------
  req_t          s3_req;
  logic [IW-1:0] s3_idx;
  logic [XW-1:0] res_raw;
  logic [XW-1:0] res_fix;

  assign res_raw = s2_xlo - s2_qn;
  assign res_fix = (res_raw >= N_X) ? (res_raw - N_X) : res_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_req <= s2_req;
      s3_idx <= res_fix[IW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Table memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [EW-1:0] table_mem [ENTRIES];
  logic          rd_en;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_data;

  // read the entry as the request moves into stage 4
  assign rd_en = s3_valid && s4_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[s3_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: compare, merge, write back
  // --------------------------------------------------------------------------
  req_t          s4_req;
  logic [IW-1:0] s4_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_req <= s3_req;
      s4_idx <= s3_idx;
    end
  end

  // The write made at the same edge as this read is not in rd_data yet:
  // take it from the last-write register instead. Older writes are already
  // in the memory, so one entry of forwarding covers every case.
  logic          fwd_valid;
  logic [IW-1:0] fwd_idx;
  logic [EW-1:0] fwd_data;

  logic [EW-1:0]        old_word;
  logic [LEN_W-1:0]     old_len;
  logic [DW-1:0]        old_bytes;
  logic [BW-1:0]        req_bytes;
  logic [DW-1:0]        new_bytes;
  logic [LEN_W-1:0]     sat_len;
  logic [MAX_BYTES-1:0] lane_en;
  logic [DW-1:0]        lane_mask;
  logic                 same;
  logic [DW-1:0]        merged;
  logic                 do_write;
  logic [LEN_W-1:0]     res_len;
  logic [BW-1:0]        res_bytes;
  logic                 res_hit;
  logic [BW-1:0]        restored;

  assign old_word  = (fwd_valid && fwd_idx == s4_idx) ? fwd_data : rd_data;
  assign old_len   = old_word[EW-1:DW];
  assign old_bytes = old_word[DW-1:0];
  assign req_bytes = {s4_req.hi, s4_req.lo};
  assign new_bytes = req_bytes[DW-1:0];

  // clamp the length to the table width
  assign sat_len = (s4_req.len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : s4_req.len;

  always_comb begin
    for (int b = 0; b < MAX_BYTES; b++) begin
      lane_en[b]           = LEN_W'(b) < sat_len;
      lane_mask[8*b +: 8] = {8{lane_en[b]}};
    end
  end

  assign same   = (((old_bytes ^ new_bytes) & lane_mask) == '0) && (old_len == sat_len);
  assign merged = (old_bytes & ~lane_mask) | (new_bytes & lane_mask);

  always_comb begin
    restored         = '0;
    restored[DW-1:0] = old_bytes;
  end

  always_comb begin
    res_len   = s4_req.len;
    res_bytes = req_bytes;
    res_hit   = 1'b0;
    do_write  = 1'b0;
    if (s4_req.is_std) begin
      res_len = sat_len;
      if (mode == MODE_ENCODE) begin
        // zero length: pass as is, leave the entry alone
        if (sat_len != '0) begin
          if (same) begin
            res_len = '0;
            res_hit = 1'b1;
          end else begin
            do_write = 1'b1;
          end
        end
      end else begin
        if (sat_len == '0) begin
          // restore from the entry
          res_len   = old_len;
          res_bytes = restored;
          res_hit   = 1'b1;
        end else begin
          do_write = 1'b1;
        end
      end
    end
  end

  // the sweep owns the write port until it ends
  assign wr_en   = clearing || (s4_valid && out_ready && do_write);
  assign wr_idx  = clearing ? clr_idx : s4_idx;
  assign wr_data = clearing ? '0 : {sat_len, merged};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en && !clearing) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clearing) begin
      fwd_idx  <= wr_idx;
      fwd_data <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s4_valid) begin
      out_length     <= res_len;
      out_bytes_low  <= res_bytes[WORD_W-1:0];
      out_bytes_high <= res_bytes[BW-1:WORD_W];
      hit            <= res_hit;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sweep_blocks_requests: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("request accepted during table sweep");

  a_sweep_runs_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("table sweep restarted without reset");

  a_write_only_on_retire: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (clearing || (s4_valid && out_ready)))
    else $error("table written without a retiring request");

  a_forward_matches_table: assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> (table_mem[fwd_idx] == fwd_data))
    else $error("forwarded entry disagrees with table");

  a_hit_length_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (out_length <= LEN_W'(MAX_BYTES)))
    else $error("hit result with length beyond table width");

endmodule

[tb/insn_bytes_dedup_cache_tb.sv]
// ----------------------------------------------------------------------------
// insn_bytes_dedup_cache_tb
// Self-checking bench for the instruction byte dedup cache. A local model of
// the table predicts every result as its request is accepted. Results are
// compared in order, field by field. Directed requests cover encode and
// decode corner cases. Random traffic then runs over a small address and
// pattern pool so that hits, restores and aliasing are frequent. The traffic
// mixes in random stalls, a stretch with no idling and one long output hold.
// ----------------------------------------------------------------------------
module insn_bytes_dedup_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibdc_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int MAX_BYTES    = MAX_BYTES_DEF;
  localparam int SLOTS        = 32;
  localparam int PATTERNS     = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 100000;

  // One request as offered on the input channel
  typedef struct packed {
    logic              is_std;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } request_t;

  // One result as it should leave the output channel
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    logic              hit;
  } emitted_t;

  // Clock, reset and every block input start at known values
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  is_std      = 1'b0;
  logic [ADDR_W-1:0]     addr        = '0;
  logic [LEN_W-1:0]      instr_len   = '0;
  logic [WORD_W-1:0]     bytes_low   = '0;
  logic [WORD_W-1:0]     bytes_high  = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [LEN_W-1:0]      out_length;
  logic [WORD_W-1:0]     out_bytes_low;
  logic [WORD_W-1:0]     out_bytes_high;
  logic                  hit;

  // Model of the table: 16 bytes and a length per entry, plus the mode
  logic [127:0]      tbl_bytes [ENTRIES];
  logic [LEN_W-1:0]  tbl_len   [ENTRIES];
  mode_t             cur_mode = MODE_ENCODE;

  // Results still owed by the block, oldest first
  emitted_t pending_emits[$];

  // Random traffic pool: hot addresses and the instructions they hold
  logic [ADDR_W-1:0] slot_addr [SLOTS];
  int unsigned       slot_pat  [SLOTS];
  logic [127:0]      pat_bytes [PATTERNS];
  logic [LEN_W-1:0]  pat_len   [PATTERNS];

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          quiet      = 1'b0;  // no idling on either side while set
  int unsigned hold_asked = 0;     // bumped by a test to ask for an output hold
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;

  insn_bytes_dedup_cache dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .is_std        (is_std),
    .addr          (addr),
    .instr_len     (instr_len),
    .bytes_low     (bytes_low),
    .bytes_high    (bytes_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_length    (out_length),
    .out_bytes_low (out_bytes_low),
    .out_bytes_high(out_bytes_high),
    .hit           (hit)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up well past the slowest legal run (reset sweep included)
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Mask of the first n bytes of a 16-byte line
  function automatic logic [127:0] byte_mask(int unsigned n);
    if (n >= 16) return {128{1'b1}};
    return (128'd1 << (8 * n)) - 128'd1;
  endfunction

  // Byte-enabled write of the first n bytes; later bytes keep their value
  function automatic void store_entry(int unsigned idx, logic [LEN_W-1:0] n,
                                      logic [127:0] data);
    logic [127:0] m;
    m = byte_mask(n);
    tbl_bytes[idx] = (tbl_bytes[idx] & ~m) | (data & m);
    tbl_len[idx]   = n;
  endfunction

  // Work out what the block emits for one request and advance the table
  function automatic emitted_t dedup_predict(request_t r);
    emitted_t         e;
    int unsigned      idx;
    logic [LEN_W-1:0] n;
    logic [127:0]     data;
    logic [127:0]     m;
    idx   = r.addr % ENTRIES;
    data  = {r.hi, r.lo};
    n     = r.len;
    e.len = r.len;
    e.hi  = r.hi;
    e.lo  = r.lo;
    e.hit = 1'b0;
    // Frames that are not standard leave everything untouched
    if (r.is_std) begin
      // Clamp an oversized length; the clamped value is what counts
      if (n > MAX_BYTES) n = LEN_W'(MAX_BYTES);
      e.len = n;
      if (cur_mode == MODE_ENCODE) begin
        // Length zero neither compares nor writes
        if (n != 0) begin
          m = byte_mask(n);
          if (((tbl_bytes[idx] ^ data) & m) == '0 && tbl_len[idx] == n) begin
            e.len = '0;
            e.hit = 1'b1;
          end else begin
            store_entry(idx, n, data);
          end
        end
      end else if (n == 0) begin
        // Restore the whole stored line and its length
        e.len        = tbl_len[idx];
        {e.hi, e.lo} = tbl_bytes[idx] & byte_mask(MAX_BYTES);
        e.hit        = 1'b1;
      end else begin
        store_entry(idx, n, data);
      end
    end
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict at the edge where the request is taken
  always @(posedge clk) begin : take_requests
    request_t r;
    if (!rst && in_valid && !in_stall) begin
      r.is_std = is_std;
      r.addr   = addr;
      r.len    = instr_len;
      r.lo     = bytes_low;
      r.hi     = bytes_high;
      pending_emits.push_back(dedup_predict(r));
    end
  end

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    emitted_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_emits.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_emits.pop_front();
        if (out_length !== want.len)
          report_mismatch($sformatf("out_length %0d, want %0d", out_length, want.len));
        if (out_bytes_low !== want.lo)
          report_mismatch($sformatf("out_bytes_low %h, want %h", out_bytes_low, want.lo));
        if (out_bytes_high !== want.hi)
          report_mismatch($sformatf("out_bytes_high %h, want %h", out_bytes_high, want.hi));
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
      end
    end
  end

  // Output stall: a long hold when a test asks for one, else random stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  function automatic request_t make_request(logic std, logic [ADDR_W-1:0] a,
                                            logic [LEN_W-1:0] n, logic [127:0] data);
    request_t r;
    r.is_std     = std;
    r.addr       = a;
    r.len        = n;
    {r.hi, r.lo} = data;
    return r;
  endfunction

  // Offer one request after a random gap and hold it until it is taken
  task automatic send_request(request_t r);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    is_std      <= r.is_std;
    addr        <= r.addr;
    instr_len   <= r.len;
    bytes_low   <= r.lo;
    bytes_high  <= r.hi;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_emits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the mode register while idle, then read it back
  task automatic write_mode(mode_t m);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MODE, 2'b00};
    pwdata  <= APB_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_mode = m;
    // Go straight into the read setup; psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(m))
      report_mismatch($sformatf("mode reads %h, want %h", prdata, APB_DATA_W'(m)));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly hot addresses carrying their usual instruction, some noise
  function automatic request_t random_request();
    request_t     r;
    int unsigned  roll;
    int unsigned  slot;
    int unsigned  pat;
    logic [127:0] noise;
    logic [127:0] m;
    roll         = $urandom_range(99);
    noise        = {$urandom, $urandom, $urandom, $urandom};
    r.is_std     = 1'b1;
    r.addr       = $urandom;
    r.len        = LEN_W'($urandom_range(31));
    {r.hi, r.lo} = noise;
    if (roll < 8) begin
      r.is_std = 1'b0;
    end else if (roll >= 20) begin
      slot   = $urandom_range(SLOTS - 1);
      pat    = ($urandom_range(3) != 0) ? slot_pat[slot] : $urandom_range(PATTERNS - 1);
      r.addr = slot_addr[slot];
      r.len  = pat_len[pat];
      m      = byte_mask(pat_len[pat]);
      // Junk past the length must not affect a match
      if ($urandom_range(4) == 0) {r.hi, r.lo} = (pat_bytes[pat] & m) | (noise & ~m);
      else {r.hi, r.lo} = pat_bytes[pat];
      if ($urandom_range(99) < ((cur_mode == MODE_DECODE) ? 40 : 3)) r.len = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Encode from reset: hits, misses, length mismatch, saturation, aliasing
  task automatic test_encode_cases();
    logic [127:0] insn;
    insn = 128'h0f1e2d3c4b5a6978_8796a5b4c3d2e1f0;
    send_request(make_request(1'b1, 32'd0, 5'd0, {128{1'b1}}));        // length zero
    send_request(make_request(1'b1, 32'd5, 5'd4, insn));               // miss, fill
    send_request(make_request(1'b1, 32'd5, 5'd4, insn));               // hit
    send_request(make_request(1'b1, 32'd5, 5'd3, insn));               // length differs
    send_request(make_request(1'b1, 32'd5, 5'd3, insn ^ (128'hff << 24))); // junk past len
    send_request(make_request(1'b1, 32'd5 + ENTRIES, 5'd3, insn));     // aliased address
    send_request(make_request(1'b1, 32'hffff_ffff, 5'd31, {128{1'b1}})); // saturate
    send_request(make_request(1'b1, 32'hffff_ffff, 5'd16, {128{1'b1}})); // hit at max
    send_request(make_request(1'b1, 32'hffff_ffff, 5'd16,
                              {128{1'b1}} ^ (128'd1 << 127)));         // last byte differs
    send_request(make_request(1'b0, 32'hffff_ffff, 5'd31, {128{1'b1}})); // pass through
    send_request(make_request(1'b1, 32'd9, 5'd8, insn));
    send_request(make_request(1'b1, 32'd9, 5'd9, insn));               // word boundary
    send_request(make_request(1'b1, 32'd9, 5'd9, insn));
    send_request(make_request(1'b1, 32'd2, 5'd1, 128'd0));             // zero bytes vs empty
  endtask

  // Decode: restore from empty and filled entries, partial writes
  task automatic test_decode_cases();
    logic [127:0] insn;
    insn = 128'h1122334455667788_99aabbccddeeff00;
    write_mode(MODE_DECODE);
    send_request(make_request(1'b1, 32'd777, 5'd0, {128{1'b1}}));      // never written
    send_request(make_request(1'b1, 32'd5, 5'd0, {128{1'b1}}));        // mixed old bytes
    send_request(make_request(1'b1, 32'hffff_ffff, 5'd0, 128'd0));     // full line
    send_request(make_request(1'b1, 32'd40, 5'd20, insn));             // saturated write
    send_request(make_request(1'b1, 32'd40, 5'd0, 128'd0));
    send_request(make_request(1'b1, 32'd40, 5'd5, ~insn));             // partial write
    send_request(make_request(1'b1, 32'd40, 5'd0, 128'd0));
    send_request(make_request(1'b0, 32'd40, 5'd0, {128{1'b1}}));       // pass through
  endtask

  // Random traffic over several mode settings, one phase without idling
  task automatic test_random_traffic();
    for (int i = 0; i < PATTERNS; i++) begin
      pat_bytes[i] = {$urandom, $urandom, $urandom, $urandom};
      pat_len[i]   = LEN_W'($urandom_range(1, 16));
    end
    pat_len[0] = 5'd16;
    pat_len[1] = 5'd1;
    pat_len[2] = LEN_W'($urandom_range(17, 31));
    for (int i = 0; i < SLOTS; i++) begin
      // Second half aliases onto the first half's entries
      if (i < SLOTS / 2) slot_addr[i] = $urandom;
      else slot_addr[i] = slot_addr[i - SLOTS / 2] + $urandom_range(1, 8) * ENTRIES;
      slot_pat[i] = $urandom_range(PATTERNS - 1);
    end
    for (int phase = 0; phase < 5; phase++) begin
      write_mode(phase % 2 == 0 ? MODE_ENCODE : MODE_DECODE);
      quiet = (phase == 2);
      repeat (250) send_request(random_request());
    end
    quiet = 1'b0;
  endtask

  // Hold the output for a long stretch while requests keep coming
  task automatic test_output_hold();
    write_mode(MODE_ENCODE);
    hold_asked++;
    repeat (100) send_request(random_request());
  endtask

  initial begin
    foreach (tbl_bytes[i]) begin
      tbl_bytes[i] = '0;
      tbl_len[i]   = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_encode_cases();
    test_decode_cases();
    test_random_traffic();
    test_output_hold();
    drain_results();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ibdc_pkg.sv
rtl/insn_bytes_dedup_cache.sv
tb/insn_bytes_dedup_cache_tb.sv
